@@ sv/tws_pkg.sv @@
// Shared types, widths and constants for the three-weight balance solver.
// No dependencies; imported by every module of the block.
package tws_pkg;

    localparam int VIB_W    = 20;
    localparam int PHASE_W  = 16;
    localparam int PROP_W   = 32;
    localparam int OFFS_W   = 15;
    localparam int MASS_W   = 16;
    localparam int AMT_W    = 40;
    localparam int MOVE_W   = 24;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int ANG_W    = 13;
    localparam int SUM_W    = 18;
    localparam int IMB_W    = VIB_W + PROP_W;
    localparam int WIDE_W   = IMB_W + 1;
    localparam int Q_W      = 31;
    localparam int X2_W     = 32;
    localparam int SCALE_W  = 11;
    localparam int PROD_W   = AMT_W + SCALE_W;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int RATIO_LAT       = 14;

    localparam logic signed [SUM_W-1:0]   DEG120 = 18'sd7680;
    localparam logic signed [SUM_W-1:0]   DEG180 = 18'sd11520;
    localparam logic signed [SUM_W-1:0]   DEG360 = 18'sd23040;
    localparam logic signed [PHASE_W-1:0] PH_LIM = 16'sd11520;

    localparam logic [ANG_W-1:0] ANG_90  = 13'd5760;
    localparam logic [ANG_W-1:0] ANG_120 = 13'd7680;
    localparam logic [ANG_W:0]   ANG_180 = 14'd11520;

    // x = u*292817 + floor(floor(u*7586/256)/45)  ==  floor(u*pi_q30/11520)
    localparam logic [18:0] X_INT_MUL  = 19'd292817;
    localparam logic [12:0] X_FRAC_MUL = 13'd7586;
    localparam logic [18:0] RECIP_45   = 19'd372828;
    localparam int          SH_45      = 24;

    localparam logic [Q_W-1:0] Q30_ONE    = 31'd1073741824;
    localparam logic [Q_W-1:0] INV_SIN120 = 31'd1239850262;

    localparam int          SH_110 = 39;
    localparam logic [32:0] RC_110 = 33'(((64'd1 << 39) + 64'd109) / 64'd110);
    localparam int          SH_K [4] = '{39, 38, 37, 35};
    localparam logic [32:0] RC_K [4] = '{
        33'(((64'd1 << 39) + 64'd71) / 64'd72),
        33'(((64'd1 << 38) + 64'd41) / 64'd42),
        33'(((64'd1 << 37) + 64'd19) / 64'd20),
        33'(((64'd1 << 35) + 64'd5) / 64'd6)
    };

    localparam logic [SCALE_W-1:0] MOVE_SCALE = 11'd1600;
    localparam logic [AMT_W-1:0]   AMT_MAX    = '1;
    localparam logic [MOVE_W-1:0]  MOVE_MAX   = '1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEG   = 2'd2;

    localparam logic [PROP_W-1:0]        PROP_RST = 32'd343597;
    localparam logic signed [OFFS_W-1:0] OFFS_RST = -15'sd9152;
    localparam logic [MASS_W-1:0]        MASS_RST = 16'd2560;

    typedef enum logic [2:0] {
        REG_PROP,
        REG_OFFS,
        REG_MASS_ONE,
        REG_MASS_TWO,
        REG_MASS_THREE
    } reg_idx_t;

    typedef enum logic [2:0] {
        SEC_ONE,
        SEC_TWO,
        SEC_THREE,
        SEC_ONE_TWO,
        SEC_TWO_THREE,
        SEC_THREE_ONE
    } sector_t;

    typedef struct packed {
        logic             err;
        sector_t          sector;
        logic [ANG_W-1:0] t;
        logic [VIB_W-1:0] vib;
    } item_t;

    typedef struct packed {
        logic [PROP_W-1:0] prop;
        logic [MASS_W-1:0] mass_one;
        logic [MASS_W-1:0] mass_two;
        logic [MASS_W-1:0] mass_three;
    } cfg_t;

endpackage

@@ sv/tws_front.sv @@
// Front end: input handshake, range check, correction angle and sector pick.
// Depends on tws_pkg; feeds tws_queue.
module tws_front (
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [tws_pkg::VIB_W-1:0]            vib_amount,
    input  logic signed [tws_pkg::PHASE_W-1:0]   vib_phase,
    input  logic signed [tws_pkg::OFFS_W-1:0]    phase_offset,
    input  logic                                 q_full,
    output logic                                 q_push,
    output tws_pkg::item_t                       item
);
    import tws_pkg::*;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] wrap;
    logic signed [SUM_W-1:0] ang;
    logic signed [SUM_W-1:0] tsel;
    sector_t                 sector;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        sum = SUM_W'(phase_offset) + SUM_W'(vib_phase) + DEG180;
        if (sum < 0)
            wrap = sum + DEG360;
        else if (sum >= DEG360)
            wrap = sum - DEG360;
        else
            wrap = sum;
        ang = (wrap > DEG180) ? wrap - DEG360 : wrap;
    end

    always_comb
    begin
        tsel   = '0;
        sector = SEC_ONE;
        if (ang == 0)
            sector = SEC_ONE;
        else if (ang == DEG120)
            sector = SEC_TWO;
        else if (ang == -DEG120)
            sector = SEC_THREE;
        else if (ang > 0 && ang < DEG120)
        begin
            sector = SEC_ONE_TWO;
            tsel   = ang;
        end
        else if (ang > DEG120)
        begin
            sector = SEC_TWO_THREE;
            tsel   = ang - DEG120;
        end
        else if (ang < -DEG120)
        begin
            sector = SEC_TWO_THREE;
            tsel   = ang + DEG120 + DEG120;
        end
        else
        begin
            sector = SEC_THREE_ONE;
            tsel   = ang + DEG120;
        end
    end

    always_comb
    begin
        item.err    = (vib_phase < -PH_LIM) || (vib_phase > PH_LIM);
        item.sector = sector;
        item.t      = tsel[ANG_W-1:0];
        item.vib    = vib_amount;
    end

endmodule

@@ sv/tws_queue.sv @@
// Small word queue between front end and datapath.
// Depends on tws_pkg for the queued word type.
module tws_queue #(
    parameter int DEPTH = tws_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tws_pkg::item_t wdata,
    input  logic           pop,
    output tws_pkg::item_t rdata,
    output logic           not_empty,
    output logic           full
);
    import tws_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

@@ sv/tws_ratio.sv @@
// Two-lane pipelined sine ratio R(u) = sin(u)/sin(120 deg) in Q30.
// Depends on tws_pkg; 14 stages.
module tws_ratio #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tws_pkg::ANG_W-1:0]   u_lo,
    input  logic [tws_pkg::ANG_W-1:0]   u_hi,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [tws_pkg::Q_W-1:0]     r_lo,
    output logic [tws_pkg::Q_W-1:0]     r_hi,
    output logic [SIDE_W-1:0]           out_side
);
    import tws_pkg::*;

    logic              vld_reg  [RATIO_LAT];
    logic [SIDE_W-1:0] side_reg [RATIO_LAT];
    logic [ANG_W-1:0]  u_in     [2];
    logic [Q_W-1:0]    r_out    [2];

    assign u_in[0]   = u_lo;
    assign u_in[1]   = u_hi;
    assign r_lo      = r_out[0];
    assign r_hi      = r_out[1];
    assign out_valid = vld_reg[RATIO_LAT-1];
    assign out_side  = side_reg[RATIO_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < RATIO_LAT; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < RATIO_LAT; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int s = 1; s < RATIO_LAT; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    for (genvar ln = 0; ln < 2; ln++)
    begin : g_lane
        logic [ANG_W-1:0] uf;
        logic [31:0]      p1_reg;
        logic [17:0]      n_reg;
        logic [Q_W-1:0]   x_reg  [1:11];
        logic [X2_W-1:0]  x2_reg [2:9];
        logic [Q_W-1:0]   h_reg  [5];
        logic [X2_W-1:0]  pr_reg [4];
        logic [Q_W-1:0]   sine_reg;
        logic [Q_W-1:0]   r_reg;

        assign uf        = (u_in[ln] > ANG_90) ? ANG_W'(ANG_180 - {1'b0, u_in[ln]}) : u_in[ln];
        assign r_out[ln] = r_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p1_reg    <= 32'(32'(uf) * 32'(X_INT_MUL));
                n_reg     <= 18'((26'(uf) * 26'(X_FRAC_MUL)) >> 8);
                x_reg[1]  <= Q_W'(p1_reg + 32'((37'(n_reg) * 37'(RECIP_45)) >> SH_45));
                x_reg[2]  <= x_reg[1];
                x2_reg[2] <= X2_W'((62'(x_reg[1]) * 62'(x_reg[1])) >> 30);
                for (int s = 3; s <= 11; s++)
                    x_reg[s] <= x_reg[s-1];
                for (int s = 3; s <= 9; s++)
                    x2_reg[s] <= x2_reg[s-1];
                h_reg[0]  <= Q30_ONE - Q_W'((65'(x2_reg[2]) * 65'(RC_110)) >> SH_110);
                sine_reg  <= Q_W'((62'(x_reg[11]) * 62'(h_reg[4])) >> 30);
                r_reg     <= Q_W'((62'(sine_reg) * 62'(INV_SIN120)) >> 30);
            end
        end

        for (genvar j = 0; j < 4; j++)
        begin : g_chain
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pr_reg[j]  <= X2_W'((63'(x2_reg[3+2*j]) * 63'(h_reg[j])) >> 30);
                    h_reg[j+1] <= Q30_ONE - Q_W'((65'(pr_reg[j]) * 65'(RC_K[j])) >> SH_K[j]);
                end
            end
        end
    end

endmodule

@@ sv/tws_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side word.
// Depends on tws_pkg only through the importing convention.
module tws_div #(
    parameter int DEN_W  = 16,
    parameter int QUO_W  = 24,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [QUO_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);
    import tws_pkg::*;

    logic              vld_reg  [QUO_W];
    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  nq_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    assign out_valid = vld_reg[QUO_W-1];
    assign out_quo   = nq_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        logic              vld_in;
        logic [DEN_W-1:0]  rem_in;
        logic [QUO_W-1:0]  nq_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    shifted;
        logic              ge;

        if (s == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = in_rem;
            assign nq_in   = in_num;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign nq_in   = nq_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign shifted = {rem_in, nq_in[QUO_W-1]};
        assign ge      = (shifted >= {1'b0, den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
                nq_reg[s]   <= {nq_in[QUO_W-2:0], ge};
                side_reg[s] <= side_in;
            end
        end
    end

endmodule

@@ sv/tws_back.sv @@
// Datapath: sine ratios, imbalance divide, split, moves and output register.
// Depends on tws_pkg, tws_ratio and tws_div.
module tws_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tws_pkg::cfg_t                 cfg,
    input  tws_pkg::item_t                q_rdata,
    input  logic                          q_not_empty,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tws_pkg::AMT_W-1:0]     amount_one,
    output logic [tws_pkg::AMT_W-1:0]     amount_two,
    output logic [tws_pkg::AMT_W-1:0]     amount_three,
    output logic [tws_pkg::MOVE_W-1:0]    move_one,
    output logic [tws_pkg::MOVE_W-1:0]    move_two,
    output logic [tws_pkg::MOVE_W-1:0]    move_three,
    output logic [tws_pkg::STATUS_W-1:0]  status
);
    import tws_pkg::*;

    localparam int SPLIT   = 26;
    localparam int PP_W    = SPLIT + Q_W;
    localparam int SUMP_W  = PP_W + SPLIT;
    localparam int MSIDE_W = 2 + 3 * AMT_W;

    typedef struct packed {
        logic             err;
        sector_t          sector;
        logic [VIB_W-1:0] vib;
    } rside_t;

    typedef struct packed {
        logic           err;
        sector_t        sector;
        logic [Q_W-1:0] r_lo;
        logic [Q_W-1:0] r_hi;
    } dside_t;

    logic   en;
    logic   out_valid_reg;

    rside_t rs_in, rs_out;
    logic   rt_valid;
    logic [Q_W-1:0] rt_lo, rt_hi;

    dside_t ds_in, ds_out;
    logic   dv_valid;
    logic [IMB_W-1:0] dv_quo, imb;

    logic              sc1_valid_reg, sc1_err_reg;
    sector_t           sc1_sector_reg;
    logic [IMB_W-1:0]  sc1_a_reg;
    logic [PP_W-1:0]   pp_lo_hi_reg, pp_lo_lo_reg, pp_hi_hi_reg, pp_hi_lo_reg;

    logic [WIDE_W-1:0] sc_lo, sc_hi, a_wide;
    logic [WIDE_W-1:0] w_next [3];
    logic              sc2_valid_reg, sc2_err_reg;
    logic [WIDE_W-1:0] sc2_amt_reg [3];

    logic              m1_valid_reg, m1_err_reg;
    logic [PROD_W-1:0] m1_v_reg    [3];
    logic              m1_over_reg [3];
    logic [AMT_W-1:0]  m1_amt_reg  [3];
    logic [MASS_W-1:0] mass        [3];

    logic              mv_valid;
    logic [MOVE_W-1:0] mv_quo [3];
    logic              mv_sat [3];
    logic [MSIDE_W-1:0] ms_in, ms_out;

    logic [AMT_W-1:0]    amt_out_reg [3];
    logic [MOVE_W-1:0]   mv_out_reg  [3];
    logic [STATUS_W-1:0] status_reg;

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && q_not_empty;

    assign rs_in = '{err: q_rdata.err, sector: q_rdata.sector, vib: q_rdata.vib};

    tws_ratio #(
        .SIDE_W ($bits(rside_t))
    ) u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_not_empty),
        .u_lo      (ANG_120 - q_rdata.t),
        .u_hi      (q_rdata.t),
        .in_side   (rs_in),
        .out_valid (rt_valid),
        .r_lo      (rt_lo),
        .r_hi      (rt_hi),
        .out_side  (rs_out)
    );

    assign ds_in = '{err: rs_out.err, sector: rs_out.sector, r_lo: rt_lo, r_hi: rt_hi};

    tws_div #(
        .DEN_W  (PROP_W),
        .QUO_W  (IMB_W),
        .SIDE_W ($bits(dside_t))
    ) u_imb_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt_valid),
        .in_rem    ('0),
        .in_num    ({rs_out.vib, {PROP_W{1'b0}}}),
        .den       (cfg.prop),
        .in_side   (ds_in),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (ds_out)
    );

    assign imb = (cfg.prop == '0) ? IMB_W'(AMT_MAX) : dv_quo;

    // split a into two 26-bit halves against each ratio
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc1_valid_reg <= 1'b0;
            sc2_valid_reg <= 1'b0;
            m1_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            sc1_valid_reg <= dv_valid;
            sc2_valid_reg <= sc1_valid_reg;
            m1_valid_reg  <= sc2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc1_err_reg    <= ds_out.err;
            sc1_sector_reg <= ds_out.sector;
            sc1_a_reg      <= imb;
            pp_lo_hi_reg   <= PP_W'(PP_W'(imb[IMB_W-1:SPLIT]) * PP_W'(ds_out.r_lo));
            pp_lo_lo_reg   <= PP_W'(PP_W'(imb[SPLIT-1:0]) * PP_W'(ds_out.r_lo));
            pp_hi_hi_reg   <= PP_W'(PP_W'(imb[IMB_W-1:SPLIT]) * PP_W'(ds_out.r_hi));
            pp_hi_lo_reg   <= PP_W'(PP_W'(imb[SPLIT-1:0]) * PP_W'(ds_out.r_hi));
        end
    end

    always_comb
    begin
        sc_lo  = WIDE_W'(((SUMP_W'(pp_lo_hi_reg) << SPLIT) + SUMP_W'(pp_lo_lo_reg)) >> 30);
        sc_hi  = WIDE_W'(((SUMP_W'(pp_hi_hi_reg) << SPLIT) + SUMP_W'(pp_hi_lo_reg)) >> 30);
        a_wide = WIDE_W'(sc1_a_reg);
        for (int w = 0; w < 3; w++)
            w_next[w] = '0;
        case (sc1_sector_reg)
            SEC_ONE:       w_next[0] = a_wide;
            SEC_TWO:       w_next[1] = a_wide;
            SEC_THREE:     w_next[2] = a_wide;
            SEC_ONE_TWO:
            begin
                w_next[0] = sc_lo;
                w_next[1] = sc_hi;
            end
            SEC_TWO_THREE:
            begin
                w_next[1] = sc_lo;
                w_next[2] = sc_hi;
            end
            SEC_THREE_ONE:
            begin
                w_next[2] = sc_lo;
                w_next[0] = sc_hi;
            end
            default:
            begin
                w_next[0] = '0;
            end
        endcase
    end

    assign mass[0] = cfg.mass_one;
    assign mass[1] = cfg.mass_two;
    assign mass[2] = cfg.mass_three;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc2_err_reg <= sc1_err_reg;
            m1_err_reg  <= sc2_err_reg;
            for (int w = 0; w < 3; w++)
            begin
                sc2_amt_reg[w] <= w_next[w];
                m1_over_reg[w] <= (sc2_amt_reg[w] > WIDE_W'(AMT_MAX));
                m1_amt_reg[w]  <= (sc2_amt_reg[w] > WIDE_W'(AMT_MAX)) ? AMT_MAX
                                                                       : sc2_amt_reg[w][AMT_W-1:0];
                m1_v_reg[w]    <= PROD_W'(PROD_W'(sc2_amt_reg[w][AMT_W-1:0]) * PROD_W'(MOVE_SCALE));
            end
        end
    end

    assign ms_in = {m1_err_reg, m1_amt_reg[0], m1_amt_reg[1], m1_amt_reg[2],
                    m1_over_reg[0] || mass[0] == '0 ||
                    m1_v_reg[0][PROD_W-1:MOVE_W] >= (PROD_W - MOVE_W)'(mass[0])};

    for (genvar w = 0; w < 3; w++)
    begin : g_move
        logic sat_in;

        assign sat_in = m1_over_reg[w] || mass[w] == '0 ||
                        m1_v_reg[w][PROD_W-1:MOVE_W] >= (PROD_W - MOVE_W)'(mass[w]);

        if (w == 0)
        begin : g_main
            tws_div #(
                .DEN_W  (MASS_W),
                .QUO_W  (MOVE_W),
                .SIDE_W (MSIDE_W)
            ) u_move_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (m1_valid_reg),
                .in_rem    (m1_v_reg[w][MOVE_W+MASS_W-1:MOVE_W]),
                .in_num    (m1_v_reg[w][MOVE_W-1:0]),
                .den       (mass[w]),
                .in_side   (ms_in),
                .out_valid (mv_valid),
                .out_quo   (mv_quo[w]),
                .out_side  (ms_out)
            );
            assign mv_sat[w] = ms_out[0];
        end
        else
        begin : g_aux
            logic aux_valid;

            tws_div #(
                .DEN_W  (MASS_W),
                .QUO_W  (MOVE_W),
                .SIDE_W (1)
            ) u_move_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (m1_valid_reg),
                .in_rem    (m1_v_reg[w][MOVE_W+MASS_W-1:MOVE_W]),
                .in_num    (m1_v_reg[w][MOVE_W-1:0]),
                .den       (mass[w]),
                .in_side   (sat_in),
                .out_valid (aux_valid),
                .out_quo   (mv_quo[w]),
                .out_side  (mv_sat[w])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= mv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            amt_out_reg[0] <= ms_out[MSIDE_W-1] ? '0 : ms_out[MSIDE_W-2 -: AMT_W];
            amt_out_reg[1] <= ms_out[MSIDE_W-1] ? '0 : ms_out[MSIDE_W-2-AMT_W -: AMT_W];
            amt_out_reg[2] <= ms_out[MSIDE_W-1] ? '0 : ms_out[MSIDE_W-2-2*AMT_W -: AMT_W];
            for (int w = 0; w < 3; w++)
            begin
                if (ms_out[MSIDE_W-1])
                    mv_out_reg[w] <= '0;
                else
                    mv_out_reg[w] <= mv_sat[w] ? MOVE_MAX : mv_quo[w];
            end
            status_reg <= ms_out[MSIDE_W-1] ? ST_RANGE : ST_OK;
        end
    end

    assign out_valid    = out_valid_reg;
    assign amount_one   = amt_out_reg[0];
    assign amount_two   = amt_out_reg[1];
    assign amount_three = amt_out_reg[2];
    assign move_one     = mv_out_reg[0];
    assign move_two     = mv_out_reg[1];
    assign move_three   = mv_out_reg[2];
    assign status       = status_reg;

endmodule

@@ sv/three_weight_balance_solver_unit.sv @@
// Three-weight rotor balance solver: one vibration word in (amplitude, phase),
// one correction word out (amount and move for the weights at 0, 120 and 240 deg).
// Sustains one word per clock while out_ready is high; a word passes 14 sine ratio
// stages, the 52-stage imbalance divider, three scale and split stages, the 24-stage
// move dividers and the output register. A low out_ready with out_valid high freezes
// the whole back end. Registers sit on an APB port at 4*index.
module three_weight_balance_solver_unit #(
    parameter int QUEUE_DEPTH = tws_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tws_pkg::ADDR_W-1:0]          paddr,
    input  logic [tws_pkg::DATA_W-1:0]          pwdata,
    output logic [tws_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tws_pkg::VIB_W-1:0]           vib_amount,
    input  logic signed [tws_pkg::PHASE_W-1:0]  vib_phase,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tws_pkg::AMT_W-1:0]           amount_one,
    output logic [tws_pkg::AMT_W-1:0]           amount_two,
    output logic [tws_pkg::AMT_W-1:0]           amount_three,
    output logic [tws_pkg::MOVE_W-1:0]          move_one,
    output logic [tws_pkg::MOVE_W-1:0]          move_two,
    output logic [tws_pkg::MOVE_W-1:0]          move_three,
    output logic [tws_pkg::STATUS_W-1:0]        status
);
    import tws_pkg::*;

    logic [PROP_W-1:0]        prop_reg;
    logic signed [OFFS_W-1:0] offs_reg;
    logic [MASS_W-1:0]        mass_one_reg;
    logic [MASS_W-1:0]        mass_two_reg;
    logic [MASS_W-1:0]        mass_three_reg;
    reg_idx_t                 idx;
    logic                     wr_en;
    cfg_t                     cfg;

    item_t item;
    item_t q_rdata;
    logic  q_push, q_pop, q_full, q_not_empty;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_reg       <= PROP_RST;
            offs_reg       <= OFFS_RST;
            mass_one_reg   <= MASS_RST;
            mass_two_reg   <= MASS_RST;
            mass_three_reg <= MASS_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PROP:       prop_reg       <= pwdata[PROP_W-1:0];
                REG_OFFS:       offs_reg       <= $signed(pwdata[OFFS_W-1:0]);
                REG_MASS_ONE:   mass_one_reg   <= pwdata[MASS_W-1:0];
                REG_MASS_TWO:   mass_two_reg   <= pwdata[MASS_W-1:0];
                REG_MASS_THREE: mass_three_reg <= pwdata[MASS_W-1:0];
                default:        prop_reg       <= prop_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PROP:       prdata = prop_reg;
            REG_OFFS:       prdata = {{(DATA_W - OFFS_W){1'b0}}, offs_reg};
            REG_MASS_ONE:   prdata = {{(DATA_W - MASS_W){1'b0}}, mass_one_reg};
            REG_MASS_TWO:   prdata = {{(DATA_W - MASS_W){1'b0}}, mass_two_reg};
            REG_MASS_THREE: prdata = {{(DATA_W - MASS_W){1'b0}}, mass_three_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg = '{prop: prop_reg, mass_one: mass_one_reg,
                   mass_two: mass_two_reg, mass_three: mass_three_reg};

    tws_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vib_amount   (vib_amount),
        .vib_phase    (vib_phase),
        .phase_offset (offs_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .item         (item)
    );

    tws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (item),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    tws_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_rdata      (q_rdata),
        .q_not_empty  (q_not_empty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .amount_one   (amount_one),
        .amount_two   (amount_two),
        .amount_three (amount_three),
        .move_one     (move_one),
        .move_two     (move_two),
        .move_three   (move_three),
        .status       (status)
    );

    a_range_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RANGE |->
            amount_one == '0 && amount_two == '0 && amount_three == '0 &&
            move_one == '0 && move_two == '0 && move_three == '0)
        else $error("range error word carries nonzero fields");

    a_no_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != ST_NEG)
        else $error("negative move status produced");

    a_two_weights: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |->
            amount_one == '0 || amount_two == '0 || amount_three == '0)
        else $error("correction spread over all three weights");

endmodule
